### sv/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list editor package
// Action, status and cell control codes shared by the cell row and the top.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int ValueWidth    = 32;
  localparam int PositionWidth = 5;
  localparam int MaxResults    = 16;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD      = 3'd0,
    CELL_LOAD      = 3'd1,
    CELL_FROM_LOW  = 3'd2,
    CELL_FROM_HIGH = 3'd3,
    CELL_FROM_HEAD = 3'd4
  } cell_mode_t;

endpackage

### sv/ple_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list editor cell
// Holds one list value and takes a new one from a load value, the neighbor
// below, the neighbor above or the head of the list.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                                clk,
  input  ple_pkg::cell_mode_t                 mode,
  input  logic [ple_pkg::ValueWidth-1:0]      load_value,
  input  logic [ple_pkg::ValueWidth-1:0]      low_data,
  input  logic [ple_pkg::ValueWidth-1:0]      high_data,
  input  logic [ple_pkg::ValueWidth-1:0]      head_data,
  output logic [ple_pkg::ValueWidth-1:0]      data
);

  logic [ple_pkg::ValueWidth-1:0] data_next;

  always_comb begin
    unique case (mode)
      ple_pkg::CELL_HOLD:      data_next = data;
      ple_pkg::CELL_LOAD:      data_next = load_value;
      ple_pkg::CELL_FROM_LOW:  data_next = low_data;
      ple_pkg::CELL_FROM_HIGH: data_next = high_data;
      ple_pkg::CELL_FROM_HEAD: data_next = head_data;
      default:                 data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### sv/positional_list_editor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list editor
// Ordered list of signed values held in a row of cells, edited by position.
// ----------------------------------------------------------------------------
// An append, insert or delete is applied at the accepting edge: the cells load
// the value or shift by one place, and a single status beat with the new length
// follows on the next cycle, so edits can be issued back to back. A dump of a
// list of length N keeps busy high while the row rotates toward the head,
// emitting one beat per value from cell zero (at most 16 beats, last
// set on the final one); a dump of an empty list gives one empty-status beat
// and no busy time. Result beats appear for one cycle with done high and
// cannot be held off.
module positional_list_editor_top #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action,
  input  logic [4:0]          position,
  input  logic signed [31:0]  value,
  output logic                done,
  output logic signed [31:0]  item_value,
  output logic [4:0]          item_position,
  output logic [1:0]          status,
  output logic                last
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int XW = (LW > ple_pkg::PositionWidth) ? LW : ple_pkg::PositionWidth;
  localparam int CW = XW + 1;

  ple_pkg::cell_mode_t            mode [CAPACITY];
  logic [ple_pkg::ValueWidth-1:0] cell_data [CAPACITY];

  logic [LW-1:0] length;
  logic [LW-1:0] length_next;
  logic [LW-1:0] count;
  logic          dumping;

  logic          accept;
  logic          append_ok;
  logic          insert_ok;
  logic          delete_ok;
  logic [CW-1:0] pos_x;
  logic [CW-1:0] len_x;
  logic [CW-1:0] cnt_x;
  logic [CW-1:0] nout;
  ple_pkg::action_t act;
  ple_pkg::status_t edit_status;

  assign accept = start & ~busy;
  assign busy   = dumping;
  assign act    = ple_pkg::action_t'(action);
  assign pos_x  = CW'(position);
  assign len_x  = CW'(length);
  assign cnt_x  = CW'(count);
  assign nout   = (len_x > CW'(ple_pkg::MaxResults)) ? CW'(ple_pkg::MaxResults) : len_x;

  assign append_ok = accept && (act == ple_pkg::ACT_APPEND) && (len_x < CW'(CAPACITY));
  assign insert_ok = accept && (act == ple_pkg::ACT_INSERT) && (pos_x <= len_x)
                     && (len_x < CW'(CAPACITY));
  assign delete_ok = accept && (act == ple_pkg::ACT_DELETE) && (pos_x != '0)
                     && (pos_x <= len_x);

  always_comb begin
    priority if (act == ple_pkg::ACT_APPEND) begin
      edit_status = (len_x < CW'(CAPACITY)) ? ple_pkg::ST_OK : ple_pkg::ST_FULL;
    end else if (act == ple_pkg::ACT_INSERT) begin
      if (pos_x > len_x) begin
        edit_status = ple_pkg::ST_NOT_FOUND;
      end else if (len_x >= CW'(CAPACITY)) begin
        edit_status = ple_pkg::ST_FULL;
      end else begin
        edit_status = ple_pkg::ST_OK;
      end
    end else begin
      edit_status = delete_ok ? ple_pkg::ST_OK : ple_pkg::ST_NOT_FOUND;
    end
  end

  always_comb begin
    priority if (append_ok || insert_ok) begin
      length_next = length + LW'(1);
    end else if (delete_ok) begin
      length_next = length - LW'(1);
    end else begin
      length_next = length;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    logic [ple_pkg::ValueWidth-1:0] low_data;
    logic [ple_pkg::ValueWidth-1:0] high_data;

    if (i == 0) begin : g_low_edge
      assign low_data = '0;
    end else begin : g_low
      assign low_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_high_edge
      assign high_data = '0;
    end else begin : g_high
      assign high_data = cell_data[i+1];
    end

    always_comb begin
      mode[i] = ple_pkg::CELL_HOLD;
      if (dumping) begin
        if (Idx + CW'(1) < len_x) begin
          mode[i] = ple_pkg::CELL_FROM_HIGH;
        end else if (Idx + CW'(1) == len_x) begin
          mode[i] = ple_pkg::CELL_FROM_HEAD;
        end
      end else if (append_ok) begin
        if (Idx == len_x) begin
          mode[i] = ple_pkg::CELL_LOAD;
        end
      end else if (insert_ok) begin
        if (Idx == pos_x) begin
          mode[i] = ple_pkg::CELL_LOAD;
        end else if ((Idx > pos_x) && (Idx <= len_x)) begin
          mode[i] = ple_pkg::CELL_FROM_LOW;
        end
      end else if (delete_ok) begin
        if ((Idx + CW'(1) >= pos_x) && (Idx + CW'(1) < len_x)) begin
          mode[i] = ple_pkg::CELL_FROM_HIGH;
        end
      end
    end

    ple_cell u_cell (
      .clk        (clk),
      .mode       (mode[i]),
      .load_value (value),
      .low_data   (low_data),
      .high_data  (high_data),
      .head_data  (cell_data[0]),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length  <= '0;
      dumping <= 1'b0;
      done    <= 1'b0;
    end else begin
      length <= length_next;
      done   <= 1'b0;
      if (dumping) begin
        done  <= (cnt_x < nout);
        count <= count + LW'(1);
        if (cnt_x + CW'(1) == len_x) begin
          dumping <= 1'b0;
        end
      end else if (accept) begin
        done <= 1'b1;
        if ((act == ple_pkg::ACT_DUMP) && (length != '0)) begin
          dumping <= 1'b1;
          done    <= 1'b0;
          count   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dumping) begin
      logic [CW-1:0] next_pos;
      next_pos      = cnt_x + CW'(1);
      item_value    <= cell_data[0];
      item_position <= next_pos[4:0];
      status        <= ple_pkg::ST_OK;
      last          <= (next_pos == nout);
    end else if (accept) begin
      logic [CW-1:0] new_len;
      new_len    = CW'(length_next);
      item_value <= '0;
      last       <= 1'b1;
      if (act == ple_pkg::ACT_DUMP) begin
        item_position <= '0;
        status        <= ple_pkg::ST_EMPTY;
      end else begin
        item_position <= new_len[4:0];
        status        <= edit_status;
      end
    end
  end

`ifndef SYNTH
  a_busy_nonempty : assert property (@(posedge clk) disable iff (rst)
    busy |-> (length != '0))
    else $error("dump in progress on an empty list");

  a_length_bound : assert property (@(posedge clk) disable iff (rst)
    CW'(length) <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_empty_last : assert property (@(posedge clk) disable iff (rst)
    (done && (status == ple_pkg::ST_EMPTY)) |-> (last && (item_position == '0)))
    else $error("empty-status beat not marked last");

  a_dump_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ple_pkg::ACT_DUMP) && (length != '0)) |=> busy)
    else $error("dump of a non-empty list did not go busy");

  a_dump_length_stable : assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |-> $stable(length))
    else $error("list length changed during a dump");
`endif

endmodule

### verif/positional_list_editor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list editor checker
// Watches the command and result ports of the list editor and keeps its own
// copy of the list. Every accepted command is turned into the result beats
// it must cause. Each result beat is compared field by field with the oldest
// beat still awaited. The mismatch count and the number of awaited beats are
// passed to the testbench top.
// ----------------------------------------------------------------------------
module positional_list_editor_checker
  import ple_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         action,
  input  logic [4:0]         position,
  input  logic signed [31:0] value,
  input  logic               done,
  input  logic signed [31:0] item_value,
  input  logic [4:0]         item_position,
  input  logic [1:0]         status,
  input  logic               last,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic signed [31:0] beat_value;
    logic [4:0]         beat_position;
    status_t            beat_status;
    logic               beat_last;
  } list_beat_t;

  logic signed [31:0] list_cells [CAPACITY];
  int                 list_len;
  list_beat_t         awaited_beats [$];
  int                 error_count;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    error_count = 0;
    list_len    = 0;
  end

  task automatic push_beat(input logic signed [31:0] val, input int pos, input status_t st,
                           input logic lst);
    list_beat_t beat;
    beat.beat_value    = val;
    beat.beat_position = pos[4:0];
    beat.beat_status   = st;
    beat.beat_last     = lst;
    awaited_beats.push_back(beat);
  endtask

  task automatic place_value(input int idx, input logic signed [31:0] val);
    int i;
    for (i = list_len; i > idx; i--) begin
      list_cells[i] = list_cells[i - 1];
    end
    list_cells[idx] = val;
    list_len++;
  endtask

  task automatic apply_list_command(input action_t act, input logic [4:0] pos,
                                    input logic signed [31:0] val);
    int      i;
    int      count;
    status_t st;
    st = ST_OK;
    if (act == ACT_DUMP) begin
      if (list_len == 0) begin
        push_beat(32'sd0, 0, ST_EMPTY, 1'b1);
      end else begin
        count = (list_len > MaxResults) ? MaxResults : list_len;
        for (i = 0; i < count; i++) begin
          push_beat(list_cells[i], i + 1, ST_OK, (i + 1 == count));
        end
      end
    end else begin
      case (act)
        ACT_APPEND: begin
          if (list_len >= CAPACITY) st = ST_FULL;
          else place_value(list_len, val);
        end
        ACT_INSERT: begin
          if (int'(pos) > list_len) st = ST_NOT_FOUND;
          else if (list_len >= CAPACITY) st = ST_FULL;
          else place_value(int'(pos), val);
        end
        default: begin
          if (pos == 5'd0 || int'(pos) > list_len) begin
            st = ST_NOT_FOUND;
          end else begin
            for (i = int'(pos) - 1; i + 1 < list_len; i++) begin
              list_cells[i] = list_cells[i + 1];
            end
            list_len--;
          end
        end
      endcase
      push_beat(32'sd0, list_len, st, 1'b1);
    end
  endtask

  task automatic flag_mismatch(input string expected_text);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: beat mismatch: expected %s, got value %0d position %0d status %0d last %0d",
               $realtime, expected_text, item_value, item_position, status, last);
    end
  endtask

  always @(posedge clk) begin
    list_beat_t beat;
    if (rst) begin
      list_len = 0;
      awaited_beats.delete();
    end else begin
      if (start && !busy) begin
        apply_list_command(action_t'(action), position, value);
      end
      if (done) begin
        if (awaited_beats.size() == 0) begin
          flag_mismatch("no beat");
        end else begin
          beat = awaited_beats.pop_front();
          if (item_value !== beat.beat_value || item_position !== beat.beat_position ||
              status !== beat.beat_status || last !== beat.beat_last) begin
            flag_mismatch($sformatf("value %0d position %0d status %0d last %0d",
                                    beat.beat_value, beat.beat_position,
                                    beat.beat_status, beat.beat_last));
          end
        end
      end
    end
    mismatches  <= error_count;
    outstanding <= awaited_beats.size();
  end

endmodule

### verif/tb_positional_list_editor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list editor testbench
// Drives append, insert, delete and dump commands into the list editor: a
// directed opening over empty, partly filled and full lists, then random
// commands in alternating grow and shrink phases, sent in bursts with random
// gaps. The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_positional_list_editor_top;
  import ple_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int RANDOM_ITEMS   = 420;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         action;
  logic [4:0]         position;
  logic signed [31:0] value;
  logic               done;
  logic signed [31:0] item_value;
  logic [4:0]         item_position;
  logic [1:0]         status;
  logic               last;
  int                 mismatches;
  int                 outstanding;
  int                 idle_cycles;
  int                 burst_left;
  int                 shadow_len;

  positional_list_editor_top #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .position(position), .value(value),
    .done(done), .item_value(item_value), .item_position(item_position),
    .status(status), .last(last)
  );

  positional_list_editor_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .position(position), .value(value),
    .done(done), .item_value(item_value), .item_position(item_position),
    .status(status), .last(last),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: pick_value = 32'sh8000_0000;
      1: pick_value = 32'sh7fff_ffff;
      2: pick_value = 32'sd0;
      3: pick_value = -32'sd1;
      default: pick_value = $urandom;
    endcase
  endfunction

  task automatic send_command(input action_t act, input logic [4:0] pos,
                              input logic signed [31:0] val);
    int gap;
    start    <= 1'b1;
    action   <= act;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (act)
      ACT_APPEND: if (shadow_len < CAPACITY) shadow_len++;
      ACT_INSERT: if (int'(pos) <= shadow_len && shadow_len < CAPACITY) shadow_len++;
      ACT_DELETE: if (pos != 5'd0 && int'(pos) <= shadow_len) shadow_len--;
      default: ;
    endcase
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap = $urandom_range(0, 18);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_positional_list_editor_top: done, errors");
    $finish;
  end

  initial begin
    action_t act;
    logic [4:0] pos;
    bit grow;
    int n;
    rst        <= 1'b1;
    start      <= 1'b0;
    action     <= ACT_APPEND;
    position   <= 5'd0;
    value      <= 32'sd0;
    shadow_len = 0;
    burst_left = 4;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(ACT_DUMP, 5'd0, 32'sd0);
    send_command(ACT_DELETE, 5'd0, 32'sd0);
    send_command(ACT_INSERT, 5'd1, 32'sd5);
    send_command(ACT_INSERT, 5'd0, 32'sh7fff_ffff);
    send_command(ACT_APPEND, 5'd31, 32'sh8000_0000);
    send_command(ACT_INSERT, 5'd2, -32'sd1);
    send_command(ACT_INSERT, 5'd1, 32'sh5555_5555);
    send_command(ACT_DELETE, 5'd0, 32'sd0);
    send_command(ACT_DELETE, 5'd5, 32'sd0);
    send_command(ACT_DELETE, 5'd1, 32'sd0);
    send_command(ACT_DUMP, 5'd16, 32'sd0);
    while (shadow_len < CAPACITY) send_command(ACT_APPEND, 5'd0, pick_value());
    send_command(ACT_APPEND, 5'd0, 32'sh2aaa_aaaa);
    send_command(ACT_INSERT, 5'd16, 32'sd7);
    send_command(ACT_INSERT, 5'd17, 32'sd7);
    send_command(ACT_DUMP, 5'd0, 32'sd0);
    send_command(ACT_DELETE, 5'd16, 32'sd0);

    grow = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) grow = ~grow;
      case ($urandom_range(0, 19))
        0, 1, 2:                act = ACT_DUMP;
        3, 4, 5, 6, 7, 8, 9:    act = grow ? ACT_APPEND : ACT_DELETE;
        10, 11, 12, 13, 14, 15: act = grow ? ACT_INSERT : ACT_DELETE;
        16, 17:                 act = grow ? ACT_DELETE : ACT_INSERT;
        default:                act = ACT_APPEND;
      endcase
      if ($urandom_range(0, 6) == 0) pos = 5'($urandom_range(0, 16));
      else if (act == ACT_DELETE)
        pos = 5'($urandom_range(1, (shadow_len == 0) ? 1 : shadow_len));
      else pos = 5'($urandom_range(0, shadow_len));
      send_command(act, pos, pick_value());
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_positional_list_editor_top: done, clean");
    end else begin
      $display("tb_positional_list_editor_top: done, errors");
    end
    $finish;
  end

endmodule

### positional_list_editor_top.f
sv/ple_pkg.sv
sv/ple_cell.sv
sv/positional_list_editor_top.sv
verif/positional_list_editor_checker.sv
verif/tb_positional_list_editor_top.sv
